@@ hw/rtl/double_ended_stack_allocator_defines.svh @@
// assertion macros shared by the allocator rtl
// no dependencies; included by the modules that carry assertions
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_DEFINES_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_DEFINES_SVH

// condition holds at every edge outside reset
`define DESA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DESA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DESA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/desa_pkg.sv @@
// types and fixed widths shared by the allocator modules
// no dependencies
package desa_pkg;

	localparam int SIZE_W  = 17;	// arena offsets, ends and footprints
	localparam int BYTES_W = 16;	// alloc_bytes, pop_count, block_offset, blocks_popped
	localparam int FREE_W  = 17;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_POP   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_END_EMPTY = 2'd2
	} status_t;

	// classified item between front and back
	typedef struct packed {
		action_t             action;
		logic                from_top;
		logic [SIZE_W-1:0]   fp;		// footprint, allocate only
		logic [BYTES_W-1:0]  pop_count;
	} item_t;

	typedef struct packed {
		logic [BYTES_W-1:0]  block_offset;
		status_t             status;
		logic [BYTES_W-1:0]  blocks_popped;
		logic [FREE_W-1:0]   free_bytes;
	} res_t;

endpackage

@@ hw/rtl/double_ended_stack_allocator.sv @@
// allocate: taken in S_IDLE, answered in S_ALLOC; next item only after the answer
// pop of n blocks: walked in S_POP, one stored size read per cycle from the size stack
//   memory; no new item until the walk ends; an empty end answers from S_IDLE
// arena_size write: both ends empty at once, top limit set in S_INIT_MUL then S_INIT_SET
// reset (arst_n low): ends span arena; counts, queue, result cleared; stacks keep data
module double_ended_stack_allocator #(
	parameter int ALIGN_BYTES = 16,
	parameter int ADDR_BITS   = 16,
	parameter int MAX_BLOCKS  = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: arena size in bytes
	input  logic                          arena_size_we,
	input  logic [desa_pkg::SIZE_W-1:0]   arena_size,
	// input item queue side
	input  logic                          push,
	output logic                          full,
	input  logic                          action,
	input  logic                          from_top,
	input  logic [desa_pkg::BYTES_W-1:0]  alloc_bytes,
	input  logic [desa_pkg::BYTES_W-1:0]  pop_count,
	// result queue side
	output logic                          empty,
	input  logic                          pop,
	output logic [desa_pkg::BYTES_W-1:0]  block_offset,
	output logic [1:0]                    status,
	output logic [desa_pkg::BYTES_W-1:0]  blocks_popped,
	output logic [desa_pkg::FREE_W-1:0]   free_bytes
);

	// two slots let the front keep accepting while the back walks a pop
	localparam int FIFO_DEPTH = 2;

	desa_pkg::item_t fr_item, bk_item;
	logic            fr_valid, fr_ready;
	logic            bk_valid, bk_take;
	desa_pkg::res_t  res;
	logic            res_valid;

	// front: capture, round the request up to the alignment, add the metadata unit
	desa_front #(
		.ALIGN_BYTES (ALIGN_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.from_top    (from_top),
		.alloc_bytes (alloc_bytes),
		.pop_count   (pop_count),
		.item_valid  (fr_valid),
		.item_ready  (fr_ready),
		.item        (fr_item)
	);

	// decoupling queue between classification and execution
	desa_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_item  (fr_item),
		.rd_valid (bk_valid),
		.rd_ready (bk_take),
		.rd_item  (bk_item)
	);

	// back: end pointers, size stacks, pop walk, result register
	desa_back #(
		.ALIGN_BYTES (ALIGN_BYTES),
		.ADDR_BITS   (ADDR_BITS),
		.MAX_BLOCKS  (MAX_BLOCKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (arena_size_we),
		.cfg_size   (arena_size),
		.item_valid (bk_valid),
		.item_take  (bk_take),
		.item       (bk_item),
		.res_pop    (pop),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result item fields straight off the output register
	assign empty         = !res_valid;
	assign block_offset  = res.block_offset;
	assign status        = res.status;
	assign blocks_popped = res.blocks_popped;
	assign free_bytes    = res.free_bytes;

endmodule

@@ hw/rtl/desa_front.sv @@
// front end: accepts items, works out the aligned footprint in two stages
// depends on desa_pkg
module desa_front #(
	parameter int ALIGN_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        action,
	input  logic                        from_top,
	input  logic [desa_pkg::BYTES_W-1:0] alloc_bytes,
	input  logic [desa_pkg::BYTES_W-1:0] pop_count,
	output logic                        item_valid,
	input  logic                        item_ready,
	output desa_pkg::item_t             item
);

	// exact division by the alignment through a reciprocal, inputs below 2^17
	localparam int LOG_A   = $clog2(ALIGN_BYTES);
	localparam int SHIFT   = 17 + LOG_A;
	localparam int RECIP   = (2**SHIFT + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = 17 + RECIP_W;
	localparam int Q_W     = PROD_W - SHIFT;
	localparam int FPM_W   = Q_W + 8;

	logic                         v_s1, v_s2;
	desa_pkg::action_t            act_s1;
	logic                         top_s1;
	logic [Q_W-1:0]               q_s1;
	logic [desa_pkg::BYTES_W-1:0] cnt_s1;
	desa_pkg::item_t              item_s2;

	logic               adv1, adv2;
	logic [16:0]        y;
	logic [PROD_W-1:0]  prod;
	logic [Q_W:0]       q1;
	logic [FPM_W-1:0]   fp_full;

	assign adv2 = !v_s2 || item_ready;
	assign adv1 = !v_s1 || adv2;
	assign full = !adv1;

	assign y    = 17'(alloc_bytes) + 17'(ALIGN_BYTES - 1);
	assign prod = PROD_W'(y) * PROD_W'(RECIP);

	assign q1      = {1'b0, q_s1} + 1'b1;
	assign fp_full = FPM_W'(q1) * FPM_W'(ALIGN_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= push;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && push) begin
			act_s1 <= desa_pkg::action_t'(action);
			top_s1 <= from_top;
			q_s1   <= prod[PROD_W-1:SHIFT];
			cnt_s1 <= pop_count;
		end
		if (adv2 && v_s1) begin
			item_s2.action    <= act_s1;
			item_s2.from_top  <= top_s1;
			item_s2.fp        <= fp_full[desa_pkg::SIZE_W-1:0];
			item_s2.pop_count <= cnt_s1;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

@@ hw/rtl/desa_fifo.sv @@
// short item queue between front and back
// depends on desa_pkg and the defines header
`include "double_ended_stack_allocator_defines.svh"
module desa_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  desa_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output desa_pkg::item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desa_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign wr_ready = cnt_q != CNT_W'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_ready && rd_valid;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_rd) rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_item;
	end

	`DESA_ASSERT_ALWAYS(a_fifo_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(DEPTH), "fifo count past depth")

endmodule

@@ hw/rtl/desa_back.sv @@
// back end: arena ends, size stacks, pop walk and result register
// depends on desa_pkg and the defines header
`include "double_ended_stack_allocator_defines.svh"
module desa_back #(
	parameter int ALIGN_BYTES = 16,
	parameter int ADDR_BITS   = 16,
	parameter int MAX_BLOCKS  = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [desa_pkg::SIZE_W-1:0]  cfg_size,
	input  logic                         item_valid,
	output logic                         item_take,
	input  desa_pkg::item_t              item,
	input  logic                         res_pop,
	output logic                         res_valid,
	output desa_pkg::res_t               res
);

	localparam int SW      = desa_pkg::SIZE_W;
	localparam int IDX_W   = $clog2(MAX_BLOCKS);
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int CAP     = (ADDR_BITS >= 16) ? 65536 : (1 << ADDR_BITS);
	localparam int RST_RND = ((CAP + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int RST_TOP = (RST_RND >= ALIGN_BYTES) ? RST_RND - ALIGN_BYTES : 0;
	localparam int LOG_A   = $clog2(ALIGN_BYTES);
	localparam int SHIFT   = 17 + LOG_A;
	localparam int RECIP   = (2**SHIFT + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = 17 + RECIP_W;
	localparam int Q_W     = PROD_W - SHIFT;
	localparam int LIM_W   = Q_W + 8;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INIT_MUL = 6'b000010,
		S_INIT_SET = 6'b000100,
		S_ALLOC    = 6'b001000,
		S_POP      = 6'b010000,
		S_HOLD     = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [SW-1:0]        bot_end_q, bot_end_d, top_end_q, top_end_d;
	logic [CNT_W-1:0]     bot_cnt_q, bot_cnt_d, top_cnt_q, top_cnt_d;
	desa_pkg::item_t      cur_q, cur_d;
	logic [desa_pkg::BYTES_W-1:0] issued_q, issued_d;
	logic                 rdv_q, rdv_d;
	logic [SW-1:0]        sz_q;
	logic [Q_W-1:0]       lim_q, lim_d;
	desa_pkg::res_t       res_q, res_d, out_q;
	logic                 out_v_q, out_free, res_load;

	logic [SW-1:0]        mem_bot [MAX_BLOCKS];
	logic [SW-1:0]        mem_top [MAX_BLOCKS];
	logic [SW-1:0]        rd_bot_q, rd_top_q, rdata;
	logic                 wr_bot, wr_top;
	logic [IDX_W-1:0]     wr_idx, rd_idx;

	logic [CNT_W-1:0]     sel_cnt, head_cnt, cnt_dec;
	logic [SW:0]          sum;
	logic                 grant, iss;
	logic [SW-1:0]        new_top, top_off;
	logic [16:0]          init_y;
	logic [PROD_W-1:0]    init_prod;
	logic [LIM_W-1:0]     lim_bytes;

	assign out_free = !out_v_q || res_pop;
	assign sel_cnt  = cur_q.from_top ? top_cnt_q : bot_cnt_q;
	assign head_cnt = item.from_top ? top_cnt_q : bot_cnt_q;
	assign cnt_dec  = sel_cnt - 1'b1;
	assign rd_idx   = cnt_dec[IDX_W-1:0];
	assign wr_idx   = sel_cnt[IDX_W-1:0];
	assign rdata    = cur_q.from_top ? rd_top_q : rd_bot_q;

	// room check: the two ends must stay strictly apart
	assign sum     = {1'b0, bot_end_q} + {1'b0, cur_q.fp};
	assign grant   = (sel_cnt < CNT_W'(MAX_BLOCKS)) && (sum < {1'b0, top_end_q});
	assign new_top = top_end_q - cur_q.fp;
	assign top_off = new_top + SW'(ALIGN_BYTES);

	assign iss = (state_q == S_POP) && (issued_q < cur_q.pop_count) && (sel_cnt != '0);

	assign init_y    = sz_q + 17'(ALIGN_BYTES - 1);
	assign init_prod = PROD_W'(init_y) * PROD_W'(RECIP);
	assign lim_bytes = LIM_W'(lim_q) * LIM_W'(ALIGN_BYTES);

	always_comb begin
		state_d   = state_q;
		bot_end_d = bot_end_q;
		top_end_d = top_end_q;
		bot_cnt_d = bot_cnt_q;
		top_cnt_d = top_cnt_q;
		cur_d     = cur_q;
		issued_d  = issued_q;
		lim_d     = lim_q;
		rdv_d     = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		item_take = 1'b0;
		wr_bot    = 1'b0;
		wr_top    = 1'b0;

		// stored footprint back from the stack read
		if (rdv_q) begin
			if (cur_q.from_top) top_end_d = top_end_q + rdata;
			else bot_end_d = bot_end_q - rdata;
		end

		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					item_take = 1'b1;
					cur_d     = item;
					issued_d  = '0;
					if (item.action == desa_pkg::ACT_ALLOC) begin
						state_d = S_ALLOC;
					end else if (head_cnt == '0) begin
						res_load     = 1'b1;
						res_d.status = desa_pkg::ST_END_EMPTY;
					end else begin
						state_d = S_POP;
					end
				end
			end
			S_INIT_MUL: begin
				lim_d   = init_prod[PROD_W-1:SHIFT];
				state_d = S_INIT_SET;
			end
			S_INIT_SET: begin
				top_end_d = (lim_bytes >= LIM_W'(ALIGN_BYTES)) ?
					SW'(lim_bytes - LIM_W'(ALIGN_BYTES)) : '0;
				state_d = S_IDLE;
			end
			S_ALLOC: begin
				res_load = 1'b1;
				state_d  = S_IDLE;
				if (!grant) begin
					res_d.status = desa_pkg::ST_NO_SPACE;
				end else if (cur_q.from_top) begin
					top_end_d          = new_top;
					top_cnt_d          = top_cnt_q + 1'b1;
					wr_top             = 1'b1;
					res_d.block_offset = top_off[desa_pkg::BYTES_W-1:0];
				end else begin
					bot_end_d          = sum[SW-1:0];
					bot_cnt_d          = bot_cnt_q + 1'b1;
					wr_bot             = 1'b1;
					res_d.block_offset = bot_end_q[desa_pkg::BYTES_W-1:0];
				end
			end
			S_POP: begin
				if (iss) begin
					issued_d = issued_q + 1'b1;
					rdv_d    = 1'b1;
					if (cur_q.from_top) top_cnt_d = cnt_dec;
					else bot_cnt_d = cnt_dec;
				end else begin
					res_load            = 1'b1;
					res_d.blocks_popped = issued_q;
					state_d             = S_IDLE;
				end
			end
			S_HOLD: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		res_d.free_bytes = top_end_d - bot_end_d;
		if (res_load && !out_free) state_d = S_HOLD;

		// register write restarts the arena; top end follows after the multiply
		if (cfg_we) begin
			state_d   = S_INIT_MUL;
			bot_end_d = '0;
			bot_cnt_d = '0;
			top_cnt_d = '0;
			rdv_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bot_end_q <= '0;
			top_end_q <= SW'(RST_TOP);
			bot_cnt_q <= '0;
			top_cnt_q <= '0;
			issued_q  <= '0;
			rdv_q     <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			bot_end_q <= bot_end_d;
			top_end_q <= top_end_d;
			bot_cnt_q <= bot_cnt_d;
			top_cnt_q <= top_cnt_d;
			issued_q  <= issued_d;
			rdv_q     <= rdv_d;
			if ((res_load || state_q == S_HOLD) && out_free) out_v_q <= 1'b1;
			else if (res_pop) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		lim_q <= lim_d;
		if (cfg_we) sz_q <= (cfg_size > SW'(CAP)) ? SW'(CAP) : cfg_size;
		if (res_load) res_q <= res_d;
		if (res_load && out_free) out_q <= res_d;
		else if (state_q == S_HOLD && out_free) out_q <= res_q;
	end

	// size stacks, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_bot) mem_bot[wr_idx] <= cur_q.fp;
		rd_bot_q <= mem_bot[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (wr_top) mem_top[wr_idx] <= cur_q.fp;
		rd_top_q <= mem_top[rd_idx];
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

	`DESA_ASSERT_ALWAYS(a_ends_ordered, clk, arst_n, bot_end_q <= top_end_q, "ends crossed")
	`DESA_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, (bot_cnt_q <= CNT_W'(MAX_BLOCKS)) && (top_cnt_q <= CNT_W'(MAX_BLOCKS)), "stack count past limit")
	`DESA_ASSERT_IMPLY(a_read_in_pop, clk, arst_n, rdv_q, state_q == S_POP, "stack read outside pop walk")
	`DESA_ASSERT_NEXT(a_bot_grant, clk, arst_n, (state_q == S_ALLOC) && grant && !cur_q.from_top && !cfg_we, bot_cnt_q == $past(bot_cnt_q) + 1'b1, "granted bottom allocate did not push")

endmodule

@@ tb/sv/double_ended_stack_allocator_tb.sv @@
// self-checking testbench for the double-ended stack allocator
// holds a scoreboard class with its own copy of the arena state and the tb top module
// depends on desa_pkg and the double_ended_stack_allocator rtl
class alloc_scoreboard;
	localparam int unsigned ALIGN = 16;
	localparam int unsigned DEPTH = 256;

	int unsigned bottom_end;
	int unsigned top_end;
	int unsigned bottom_count;
	int unsigned top_count;
	int unsigned bottom_sizes[DEPTH];
	int unsigned top_sizes[DEPTH];
	int unsigned errors;
	desa_pkg::res_t expected_replies[$];

	function new();
		errors = 0;
		set_arena(17'd65536);
	endfunction

	function int unsigned round_to_align(int unsigned x);
		return ((x + ALIGN - 1) / ALIGN) * ALIGN;
	endfunction

	// arena write: both ends empty, top limit from the clamped size
	function void set_arena(logic [16:0] value);
		int unsigned sz;
		int unsigned r;
		sz = 32'(value);
		if (sz > 65536) sz = 65536;
		r = round_to_align(sz);
		top_end = (r >= ALIGN) ? r - ALIGN : 0;
		bottom_end = 0;
		bottom_count = 0;
		top_count = 0;
	endfunction

	// works out the reply to one accepted request and queues it
	function void note_request(desa_pkg::action_t act, logic top, logic [15:0] bytes,
			logic [15:0] cnt);
		desa_pkg::res_t r;
		int unsigned fp;
		int unsigned held;
		int unsigned popped;
		r = '0;
		r.status = desa_pkg::ST_OK;
		popped = 0;
		if (act == desa_pkg::ACT_ALLOC) begin
			fp = round_to_align(32'(bytes)) + ALIGN;
			held = top ? top_count : bottom_count;
			if (held >= DEPTH || bottom_end + fp >= top_end) begin
				r.status = desa_pkg::ST_NO_SPACE;
			end else if (top) begin
				top_end -= fp;
				r.block_offset = 16'(top_end + ALIGN);
				top_sizes[top_count] = fp;
				top_count++;
			end else begin
				r.block_offset = 16'(bottom_end);
				bottom_end += fp;
				bottom_sizes[bottom_count] = fp;
				bottom_count++;
			end
		end else if (top) begin
			if (top_count == 0) r.status = desa_pkg::ST_END_EMPTY;
			else while (popped < 32'(cnt) && top_count > 0) begin
				top_count--;
				top_end += top_sizes[top_count];
				popped++;
			end
		end else begin
			if (bottom_count == 0) r.status = desa_pkg::ST_END_EMPTY;
			else while (popped < 32'(cnt) && bottom_count > 0) begin
				bottom_count--;
				bottom_end -= bottom_sizes[bottom_count];
				popped++;
			end
		end
		r.blocks_popped = 16'(popped);
		r.free_bytes = 17'(top_end - bottom_end);
		expected_replies.push_back(r);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_reply(logic [15:0] offset, logic [1:0] st, logic [15:0] popped,
			logic [16:0] free_b);
		desa_pkg::res_t want;
		if (expected_replies.size() == 0) begin
			$display("%0t unexpected reply: expected none, actual offset %0d status %0d popped %0d free %0d",
				$time, offset, st, popped, free_b);
			errors++;
		end else begin
			want = expected_replies.pop_front();
			compare_field("block_offset", 32'(want.block_offset), 32'(offset));
			compare_field("status", 32'(want.status), 32'(st));
			compare_field("blocks_popped", 32'(want.blocks_popped), 32'(popped));
			compare_field("free_bytes", 32'(want.free_bytes), 32'(free_b));
		end
	endfunction
endclass

module double_ended_stack_allocator_tb;

	// generous bound: every item a full 256-block pop plus long stalls on both sides
	localparam int unsigned CYCLE_LIMIT = 4000000;

	logic                                clk;
	logic                                arst_n;
	logic                                arena_size_we;
	logic [desa_pkg::SIZE_W-1:0]         arena_size;
	logic                                push;
	logic                                full;
	logic                                action;
	logic                                from_top;
	logic [desa_pkg::BYTES_W-1:0]        alloc_bytes;
	logic [desa_pkg::BYTES_W-1:0]        pop_count;
	logic                                empty;
	logic                                pop;
	logic [desa_pkg::BYTES_W-1:0]        block_offset;
	logic [1:0]                          status;
	logic [desa_pkg::BYTES_W-1:0]        blocks_popped;
	logic [desa_pkg::FREE_W-1:0]         free_bytes;

	alloc_scoreboard book;
	int unsigned cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int unsigned arena_now;		// clamped arena size, steers the random request sizes

	double_ended_stack_allocator #(
		.ALIGN_BYTES(16),
		.ADDR_BITS(16),
		.MAX_BLOCKS(256)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.arena_size_we(arena_size_we),
		.arena_size(arena_size),
		.push(push),
		.full(full),
		.action(action),
		.from_top(from_top),
		.alloc_bytes(alloc_bytes),
		.pop_count(pop_count),
		.empty(empty),
		.pop(pop),
		.block_offset(block_offset),
		.status(status),
		.blocks_popped(blocks_popped),
		.free_bytes(free_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver side: pop decided per cycle at the falling edge
	always @(negedge clk) begin
		pop <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// every reply taken at a rising edge goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			book.check_reply(block_offset, status, blocks_popped, free_bytes);
	end

	// offers one item, holds it until taken; called and returns at a falling edge
	task automatic send_item(desa_pkg::action_t act, logic top, logic [15:0] bytes,
			logic [15:0] cnt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		action <= act;
		from_top <= top;
		alloc_bytes <= bytes;
		pop_count <= cnt;
		do @(posedge clk); while (full);
		book.note_request(act, top, bytes, cnt);
		@(negedge clk);
	endtask

	// arena writes only with the block drained
	task automatic rewrite_arena(logic [16:0] value);
		push <= 1'b0;
		while (book.expected_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		arena_size_we <= 1'b1;
		arena_size <= value;
		book.set_arena(value);
		arena_now = (value > 17'd65536) ? 65536 : 32'(value);
		@(negedge clk);
		arena_size_we <= 1'b0;
		// wait while the new top limit is set
		repeat (4) @(negedge clk);
	endtask

	// mostly small requests and short pops, some full-width values
	task automatic send_random_item();
		int kind;
		int unsigned cap;
		logic top;
		kind = $urandom_range(0, 99);
		top = 1'($urandom_range(0, 1));
		cap = arena_now / 8;
		if (cap < 16) cap = 16;
		if (cap > 1024) cap = 1024;
		if (kind < 50)
			send_item(desa_pkg::ACT_ALLOC, top, 16'($urandom_range(0, cap)), 16'($urandom));
		else if (kind < 60)
			send_item(desa_pkg::ACT_ALLOC, top, 16'($urandom), 16'($urandom));
		else if (kind < 90)
			send_item(desa_pkg::ACT_POP, top, 16'($urandom), 16'($urandom_range(0, 4)));
		else if (kind < 97)
			send_item(desa_pkg::ACT_POP, top, 16'($urandom), 16'($urandom));
		else
			send_item(desa_pkg::ACT_POP, top, 16'($urandom), 16'hFFFF);
	endtask

	initial begin
		book = new();
		send_idle_pct = 34;
		recv_idle_pct = 76;
		arena_now = 65536;
		arst_n <= 1'b0;
		arena_size_we <= 1'b0;
		arena_size <= '0;
		push <= 1'b0;
		action <= 1'b0;
		from_top <= 1'b0;
		alloc_bytes <= '0;
		pop_count <= '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset arena of 64k, top limit 65520
		send_item(desa_pkg::ACT_POP, 1'b0, 16'd0, 16'd1);		// empty bottom end
		send_item(desa_pkg::ACT_POP, 1'b1, 16'd0, 16'hFFFF);		// empty top end
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'd0, 16'd0);		// zero bytes, metadata only
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'd1, 16'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'd16, 16'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'd17, 16'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'hFFFF, 16'd0);	// no room
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'hFFFF, 16'd0);
		send_item(desa_pkg::ACT_POP, 1'b0, 16'd0, 16'd0);		// pop of zero on a held end
		send_item(desa_pkg::ACT_POP, 1'b1, 16'd0, 16'd1);
		send_item(desa_pkg::ACT_POP, 1'b0, 16'd0, 16'hFFFF);		// more than held
		send_item(desa_pkg::ACT_POP, 1'b1, 16'd0, 16'hAAAA);
		send_item(desa_pkg::ACT_POP, 1'b0, 16'hFFFF, 16'd3);		// empty again, junk in the unused field
		// exact fit: ends meeting is refused, one unit short is granted
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'd65504, 16'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'd65488, 16'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'd0, 16'd0);
		send_item(desa_pkg::ACT_POP, 1'b0, 16'd0, 16'd1);
		// 32-byte arena, zero-size arena, oversized arena, one-block arena
		rewrite_arena(17'd32);
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'd0, 16'd0);
		rewrite_arena(17'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'd0, 16'd0);
		rewrite_arena(17'h1FFFF);
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'h5555, 16'd0);
		rewrite_arena(17'd48);
		send_item(desa_pkg::ACT_ALLOC, 1'b0, 16'd0, 16'd0);
		send_item(desa_pkg::ACT_ALLOC, 1'b1, 16'd0, 16'd0);

		// random segments: idle pattern changes every three, arena size every one
		for (int seg = 0; seg < 9; seg++) begin
			case (seg / 3)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg % 4)
				0: rewrite_arena(17'd65536);
				1: rewrite_arena(17'($urandom_range(32, 65536)));
				2: rewrite_arena(17'($urandom_range(32, 1024)));
				default: rewrite_arena(17'($urandom_range(65537, 131071)));
			endcase
			// fill one size stack past its depth, then drain it in one pop
			if (seg == 0 || seg == 4) begin
				logic top;
				top = 1'($urandom_range(0, 1));
				repeat (260) send_item(desa_pkg::ACT_ALLOC, top, 16'($urandom_range(0, 16)),
					16'($urandom));
				send_item(desa_pkg::ACT_POP, top, 16'($urandom), 16'd300);
			end
			repeat (150) send_random_item();
		end

		// drain, then leave room for a stray reply
		push <= 1'b0;
		while (book.expected_replies.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (book.errors == 0 && book.expected_replies.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/desa_pkg.sv
hw/rtl/desa_front.sv
hw/rtl/desa_fifo.sv
hw/rtl/desa_back.sv
hw/rtl/double_ended_stack_allocator.sv
tb/sv/double_ended_stack_allocator_tb.sv
